// File: design/interval_list_subtract_macros.svh
// Assertion macros shared by the interval list subtract design.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef INTERVAL_LIST_SUBTRACT_MACROS_SVH
`define INTERVAL_LIST_SUBTRACT_MACROS_SVH

// The condition must hold at every edge outside reset.
`define ILS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ils_pkg.sv
// Shared types, sizes and opcodes of the interval list subtract block.
// Used by every module of the design but ils_ram; depends on nothing.
package ils_pkg;

    localparam int MAX_INTERVALS = 8;
    localparam int FRAC_BITS     = 16;

    localparam int POS_W       = FRAC_BITS + 1;
    localparam int IDX_W       = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W       = $clog2(MAX_INTERVALS + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 * (1 << IDX_W);
    localparam int CNT_FIELD_W = 4;
    localparam int OP_W        = 2;

    localparam int IN_DATA_W  = ((2 * POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((CNT_FIELD_W + 2 * POS_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    localparam logic [POS_W-1:0] ONE_POS = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERVALS);

    localparam logic [OP_W-1:0] OP_RESET    = 2'd0;
    localparam logic [OP_W-1:0] OP_SUBTRACT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ     = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] b;
        logic [POS_W-1:0] e;
    } t_span;

    localparam int SPAN_W = $bits(t_span);

    // Outcome of cutting one stored interval.
    typedef struct packed {
        logic [1:0] pieces;
        logic       split;
        t_span      first;
        t_span      second;
    } t_eval;

    typedef struct packed {
        logic                   status;
        logic [CNT_FIELD_W-1:0] count;
        t_span                  span;
        logic                   empty;
        logic                   last;
    } t_result;

    function automatic logic [CNT_FIELD_W-1:0] cnt_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+CNT_FIELD_W-1:0] x;
        x = {{CNT_FIELD_W{1'b0}}, c};
        return x[CNT_FIELD_W-1:0];
    endfunction

endpackage

// File: design/ils_ram.sv
// Generic single-port-write, single-port-read memory with registered read data.
// Stand-alone; the read data holds while no read is enabled.
module ils_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ils_cut_eval.sv
// Cuts one stored interval by the hidden interval and gives the pieces that remain.
// Depends on ils_pkg for the span and result types.
module ils_cut_eval (
    input  ils_pkg::t_span                i_span,
    input  logic [ils_pkg::POS_W-1:0]     i_cut_b,
    input  logic [ils_pkg::POS_W-1:0]     i_cut_e,
    output ils_pkg::t_eval                o_eval
);

    always_comb begin
        o_eval        = '0;
        o_eval.first  = i_span;
        o_eval.second = i_span;
        priority if (i_span.e <= i_cut_b || i_span.b >= i_cut_e) begin
            o_eval.pieces = 2'd1;
        end else if (i_cut_b <= i_span.b && i_cut_e >= i_span.e) begin
            o_eval.pieces = 2'd0;
        end else if (i_cut_b > i_span.b && i_cut_e < i_span.e) begin
            // The cut lies strictly inside: keep both outer parts.
            o_eval.pieces   = 2'd2;
            o_eval.split    = 1'b1;
            o_eval.first.e  = i_cut_b;
            o_eval.second.b = i_cut_e;
        end else if (i_cut_b <= i_span.b) begin
            o_eval.pieces  = 2'd1;
            o_eval.first.b = i_cut_e;
        end else begin
            o_eval.pieces  = 2'd1;
            o_eval.first.e = i_cut_b;
        end
    end

endmodule

// File: design/ils_out_reg.sv
// Output holding register for one result word of the master-side stream.
// Depends on ils_pkg for the result type.
module ils_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ils_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output ils_pkg::t_result o_res,
    output logic             o_free
);

    logic             r_valid;
    ils_pkg::t_result r_res;

    // The slot may be refilled in the cycle its word is taken.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: design/interval_list_subtract.sv
// Top level of the interval list subtract block: sequencer, list memory and output.
// Depends on ils_pkg, ils_ram, ils_cut_eval, ils_out_reg and the assertion macros.
//
// Use: items enter on the slave stream; i_s_tuser carries the opcode (reset list,
// subtract, read) and i_s_tdata the hidden interval. Results leave on the master
// stream; o_m_tlast marks the final word caused by an item.
// The list lives in a two-bank memory. A subtract copies the list from the active
// bank into the other, one entry per cycle but for the S_SPLIT step of a split,
// writing zero, one or two pieces per entry, then swaps banks; a refused split
// leaves the active bank untouched. Reset list, empty cut and the unused opcode go
// straight to S_FIN for the result. A subtract reads the stored intervals in S_SUB,
// with an S_SPLIT step for each split interval, then reaches S_FIN. A read sends its
// words from S_READ, one word per cycle while the receiver takes them. A new item is
// taken once the previous result sits in the output register.
// After reset the block writes the initial interval [0, ONE] into the memory in
// S_BOOT before o_s_tready rises. When the receiver stalls, the finished word waits
// in the output register and the sequencer holds in S_READ or S_FIN; read data stays
// in the memory output register until it is sent.
`include "interval_list_subtract_macros.svh"

module interval_list_subtract (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // cut_begin, cut_end from bit 0 up, zero padded
    input  logic [ils_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // opcode
    input  logic [ils_pkg::OP_W-1:0]         i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // entry_count, span_begin, span_end from bit 0 up, zero padded
    output logic [ils_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // status, list_empty from bit 0 up
    output logic [ils_pkg::OUT_USER_W-1:0]   o_m_tuser,
    output logic                             o_m_tlast
);

    localparam logic [2:0] S_BOOT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SUB   = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic                        r_bank, n_bank;
    logic [ils_pkg::CNT_W-1:0]   r_count, n_count;
    logic [ils_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic [ils_pkg::CNT_W-1:0]   r_widx, n_widx;
    logic [ils_pkg::POS_W-1:0]   r_cut_b, n_cut_b;
    logic [ils_pkg::POS_W-1:0]   r_cut_e, n_cut_e;
    logic                        r_status, n_status;
    logic                        r_empty, n_empty;
    ils_pkg::t_span              r_second, n_second;

    logic                        accept;
    logic [ils_pkg::OP_W-1:0]    in_op;
    logic [ils_pkg::POS_W-1:0]   in_b, in_e;

    logic                        ram_we, ram_re;
    logic [ils_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    ils_pkg::t_span              ram_wdata, ram_rdata;
    logic [ils_pkg::SPAN_W-1:0]  ram_rbits;

    ils_pkg::t_eval              eval;
    ils_pkg::t_result            out_res, out_q;
    logic                        out_load, out_free, out_valid;

    logic                        at_last;
    logic                        refused;
    logic [ils_pkg::CNT_W-1:0]   idx_inc, widx_inc;

    assign in_op = i_s_tuser;
    assign in_b  = i_s_tdata[ils_pkg::POS_W-1:0];
    assign in_e  = i_s_tdata[2*ils_pkg::POS_W-1:ils_pkg::POS_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    ils_ram #(
        .WIDTH(ils_pkg::SPAN_W),
        .DEPTH(ils_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rbits)
    );

    assign ram_rdata = ram_rbits;

    ils_cut_eval u_eval (
        .i_span (ram_rdata),
        .i_cut_b(r_cut_b),
        .i_cut_e(r_cut_e),
        .o_eval (eval)
    );

    ils_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (out_load),
        .i_res  (out_res),
        .i_ready(i_m_tready),
        .o_valid(out_valid),
        .o_res  (out_q),
        .o_free (out_free)
    );

    assign idx_inc  = r_idx + ils_pkg::CNT_W'(1);
    assign widx_inc = r_widx + ils_pkg::CNT_W'(1);
    assign at_last  = (idx_inc == r_count);
    assign refused  = eval.split && (r_count == ils_pkg::MAX_CNT);

    always_comb begin
        n_state   = r_state;
        n_bank    = r_bank;
        n_count   = r_count;
        n_idx     = r_idx;
        n_widx    = r_widx;
        n_cut_b   = r_cut_b;
        n_cut_e   = r_cut_e;
        n_status  = r_status;
        n_empty   = r_empty;
        n_second  = r_second;
        ram_we    = 1'b0;
        ram_waddr = {r_bank, {ils_pkg::IDX_W{1'b0}}};
        ram_wdata = '{b: '0, e: ils_pkg::ONE_POS};
        ram_re    = 1'b0;
        ram_raddr = {r_bank, {ils_pkg::IDX_W{1'b0}}};
        out_load  = 1'b0;
        out_res   = '0;

        unique case (r_state)
            S_BOOT: begin
                ram_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_status = 1'b0;
                    n_empty  = 1'b0;
                    n_idx    = '0;
                    n_widx   = '0;
                    n_cut_b  = in_b;
                    n_cut_e  = in_e;
                    n_state  = S_FIN;
                    if (in_op == ils_pkg::OP_RESET) begin
                        ram_we  = 1'b1;
                        n_count = ils_pkg::CNT_W'(1);
                    end else if (in_op == ils_pkg::OP_SUBTRACT) begin
                        if (in_b < in_e && r_count != '0) begin
                            ram_re  = 1'b1;
                            n_state = S_SUB;
                        end
                    end else if (in_op == ils_pkg::OP_READ) begin
                        if (r_count == '0) begin
                            n_empty = 1'b1;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_SUB: begin
                ram_waddr = {!r_bank, r_widx[ils_pkg::IDX_W-1:0]};
                ram_wdata = eval.first;
                ram_raddr = {r_bank, idx_inc[ils_pkg::IDX_W-1:0]};
                if (refused) begin
                    // List full: the active bank keeps the old list.
                    n_status = 1'b1;
                    n_state  = S_FIN;
                end else begin
                    ram_we = (eval.pieces != 2'd0);
                    n_widx = (eval.pieces != 2'd0) ? widx_inc : r_widx;
                    n_idx  = idx_inc;
                    ram_re = !at_last;
                    if (eval.split) begin
                        n_second = eval.second;
                        n_state  = S_SPLIT;
                    end else if (at_last) begin
                        n_bank  = !r_bank;
                        n_count = (eval.pieces != 2'd0) ? widx_inc : r_widx;
                        n_state = S_FIN;
                    end
                end
            end
            S_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = {!r_bank, r_widx[ils_pkg::IDX_W-1:0]};
                ram_wdata = r_second;
                n_widx    = widx_inc;
                if (r_idx == r_count) begin
                    n_bank  = !r_bank;
                    n_count = widx_inc;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SUB;
                end
            end
            S_READ: begin
                ram_raddr = {r_bank, idx_inc[ils_pkg::IDX_W-1:0]};
                if (out_free) begin
                    out_load       = 1'b1;
                    out_res.count  = ils_pkg::cnt_field(r_count);
                    out_res.span   = ram_rdata;
                    out_res.last   = at_last;
                    n_idx          = idx_inc;
                    ram_re         = !at_last;
                    n_state        = at_last ? S_IDLE : S_READ;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_res.status = r_status;
                    out_res.count  = ils_pkg::cnt_field(r_count);
                    out_res.empty  = r_empty;
                    out_res.last   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_BOOT;
            r_bank   <= 1'b0;
            r_count  <= ils_pkg::CNT_W'(1);
            r_idx    <= '0;
            r_widx   <= '0;
            r_status <= 1'b0;
            r_empty  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_widx   <= n_widx;
            r_status <= n_status;
            r_empty  <= n_empty;
        end
        r_cut_b  <= n_cut_b;
        r_cut_e  <= n_cut_e;
        r_second <= n_second;
    end

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = ils_pkg::OUT_DATA_W'({out_q.span.e, out_q.span.b, out_q.count});
    assign o_m_tuser  = {out_q.empty, out_q.status};
    assign o_m_tlast  = out_q.last;

    `ILS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= ils_pkg::MAX_CNT, "list count above capacity")
    `ILS_ASSERT_SAME(a_load_free, i_clk, i_rst_n, out_load, out_free, "result word overwritten before taken")
    `ILS_ASSERT_SAME(a_copy_bank, i_clk, i_rst_n, ram_we && (r_state == S_SUB || r_state == S_SPLIT), ram_waddr[ils_pkg::ADDR_W-1] != r_bank, "subtract wrote into the active bank")
    `ILS_ASSERT_NEXT(a_refuse_keep, i_clk, i_rst_n, r_state == S_SUB && refused, r_bank == $past(r_bank) && r_count == $past(r_count) && r_status, "refused split changed the list")

endmodule
